// File: rtl/assert_macros.svh
// Assertion macros used by the top-level scan driver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/ssd_pkg.sv
`timescale 1ns / 1ps
package ssd_pkg;

  localparam int unsigned DIGIT_COUNT = 8;
  localparam int unsigned MEM_DEPTH   = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned WORD_W      = 16;

  localparam logic [CODE_W-1:0] BLANK_CODE  = 5'd23;
  localparam logic [CODE_W-1:0] GLYPH_COUNT = 5'd25;
  localparam logic [7:0]        POINT_SEG   = 8'h80;
  localparam logic [15:0]       HALF_RESET  = 16'd500;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_FLASH = 2'd0,
    CFG_POINT = 2'd1,
    CFG_HALF  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [CODE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] word;
  } word_req_t;

  function automatic logic [7:0] glyph_seg(input logic [CODE_W-1:0] code);
    logic [7:0] seg;
    unique case (code)
      5'd0:    seg = 8'h3F;
      5'd1:    seg = 8'h06;
      5'd2:    seg = 8'h5B;
      5'd3:    seg = 8'h4F;
      5'd4:    seg = 8'h66;
      5'd5:    seg = 8'h6D;
      5'd6:    seg = 8'h7D;
      5'd7:    seg = 8'h07;
      5'd8:    seg = 8'h7F;
      5'd9:    seg = 8'h6F;
      5'd10:   seg = 8'h77;
      5'd11:   seg = 8'h7C;
      5'd12:   seg = 8'h39;
      5'd13:   seg = 8'h5E;
      5'd14:   seg = 8'h79;
      5'd15:   seg = 8'h71;
      5'd16:   seg = 8'h76;
      5'd17:   seg = 8'h38;
      5'd18:   seg = 8'h37;
      5'd19:   seg = 8'h3E;
      5'd20:   seg = 8'h73;
      5'd21:   seg = 8'h5C;
      5'd22:   seg = 8'h40;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: rtl/ssd_ram.sv
`timescale 1ns / 1ps
module ssd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ssd_show.sv
`timescale 1ns / 1ps
module ssd_show (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [15:0]    value_i,
  output logic           busy_o,
  output ssd_pkg::mem_wr_t wr_o
);

  logic                       busy_q, busy_d;
  logic [ssd_pkg::IDX_W-1:0]  step_q, step_d;
  logic [15:0]                cur_q, cur_d;
  logic [31:0]                prod;
  logic [12:0]                quot;
  logic [15:0]                rem;

  // Divide by ten with a reciprocal; exact for every 16-bit value.
  assign prod = 32'(cur_q) * 32'd52429;
  assign quot = prod[31:19];
  assign rem  = cur_q - ((16'(quot) << 3) + (16'(quot) << 1));

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    cur_d  = cur_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      cur_d  = value_i;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      cur_d  = 16'(quot);
      if (step_q == 3'(ssd_pkg::MEM_DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // A digit above the units blanks once nothing remains of the number.
  always_comb begin
    wr_o.en   = busy_q;
    wr_o.addr = step_q;
    if ((step_q != '0) && (cur_q == '0)) begin
      wr_o.data = ssd_pkg::BLANK_CODE;
    end else begin
      wr_o.data = {1'b0, rem[3:0]};
    end
  end

  assign busy_o = busy_q;

endmodule

// File: rtl/ssd_shift.sv
`timescale 1ns / 1ps
module ssd_shift (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssd_pkg::word_req_t req_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_bit_o,
  output logic              out_last_o
);

  logic                       pw_q;
  logic [ssd_pkg::WORD_W-1:0] pw_word_q;
  logic                       sh_valid_q;
  logic [ssd_pkg::WORD_W-1:0] sh_word_q;
  logic [3:0]                 sh_cnt_q;
  logic                       fire, last, take;

  assign fire = sh_valid_q & out_ready_i;
  assign last = (sh_cnt_q == 4'(ssd_pkg::WORD_W - 1));
  assign take = pw_q & (~sh_valid_q | (fire & last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q       <= 1'b0;
      sh_valid_q <= 1'b0;
      sh_cnt_q   <= '0;
    end else begin
      if (take) begin
        pw_q <= 1'b0;
      end
      if (req_i.load) begin
        pw_q <= 1'b1;
      end
      if (take) begin
        sh_valid_q <= 1'b1;
        sh_cnt_q   <= '0;
      end else if (fire) begin
        if (last) begin
          sh_valid_q <= 1'b0;
        end
        sh_cnt_q <= sh_cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      pw_word_q <= req_i.word;
    end
    if (take) begin
      sh_word_q <= pw_word_q;
    end else if (fire) begin
      sh_word_q <= {sh_word_q[ssd_pkg::WORD_W-2:0], 1'b0};
    end
  end

  assign full_o      = pw_q;
  assign out_valid_o = sh_valid_q;
  assign out_bit_o   = sh_word_q[ssd_pkg::WORD_W-1];
  assign out_last_o  = last;

endmodule

// File: rtl/seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// Scan tick: the first bit is offered after the composing register and the one-word buffer,
// then one bit per cycle while the output is ready; 16 bits per tick. A new tick is taken
// while the shifter still sends a word, once the buffer is free. Show: one decimal digit and
// one digit RAM write per cycle. Write: one RAM write. Reset clears control state, masks,
// blink state, valid bits (half_q: HALF_RESET); an unwritten digit reads as its own index.
`include "assert_macros.svh"
module seven_segment_scan_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: number_value[15:0], digit_index[18:16], glyph_code[23:19]
  input  logic [23:0] s_axis_tdata_i,
  // tuser: action[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: serial_bit[0], zero padding above
  output logic [7:0]  m_axis_tdata_o,
  // tlast: latch_now
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  flash_q, point_q;
  logic [15:0] half_q;
  logic [15:0] blink_cnt_q, blink_cnt_d;
  logic        blink_on_q, blink_on_d;
  logic [ssd_pkg::IDX_W-1:0] scan_q, scan_d;
  logic [ssd_pkg::MEM_DEPTH-1:0] valid_q;

  logic        in_fire, tick_fire, show_fire, write_fire;
  logic        show_busy, pw_full;
  logic [15:0] cnt_inc;
  logic [ssd_pkg::IDX_W:0] scan_inc;

  logic        s1_q;
  logic [ssd_pkg::IDX_W-1:0] s1_digit_q;
  logic        s1_vbit_q, s1_blank_q, s1_point_q;

  ssd_pkg::mem_wr_t   show_wr, mem_wr;
  ssd_pkg::word_req_t word_req;
  logic [ssd_pkg::CODE_W-1:0] rdata, code;
  logic [7:0]  seg, sel;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ~show_busy & ~s1_q & ~pw_full;
  assign in_fire    = s_axis_tvalid_i & s_axis_tready_o;
  assign tick_fire  = in_fire & (s_axis_tuser_i == ssd_pkg::ACT_TICK);
  assign show_fire  = in_fire & (s_axis_tuser_i == ssd_pkg::ACT_SHOW);
  assign write_fire = in_fire & (s_axis_tuser_i == ssd_pkg::ACT_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_q <= '0;
      point_q <= '0;
      half_q  <= ssd_pkg::HALF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssd_pkg::CFG_FLASH: flash_q <= cfg_data_i[7:0];
        ssd_pkg::CFG_POINT: point_q <= cfg_data_i[7:0];
        ssd_pkg::CFG_HALF:  half_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Blink phase and scan pointer move on a tick; the new values feed this tick's word.
  assign cnt_inc  = blink_cnt_q + 16'd1;
  assign scan_inc = {1'b0, scan_q} + 4'd1;

  always_comb begin
    blink_cnt_d = blink_cnt_q;
    blink_on_d  = blink_on_q;
    scan_d      = scan_q;
    if (tick_fire) begin
      blink_cnt_d = cnt_inc;
      if (cnt_inc >= half_q) begin
        blink_cnt_d = '0;
        blink_on_d  = ~blink_on_q;
      end
      if (scan_inc >= 4'(ssd_pkg::DIGIT_COUNT)) begin
        scan_d = '0;
      end else begin
        scan_d = scan_inc[ssd_pkg::IDX_W-1:0];
      end
    end
  end

  always_comb begin
    if (show_busy) begin
      mem_wr = show_wr;
    end else begin
      mem_wr.en   = write_fire;
      mem_wr.addr = s_axis_tdata_i[18:16];
      mem_wr.data = s_axis_tdata_i[23:19];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_cnt_q <= '0;
      blink_on_q  <= 1'b0;
      scan_q      <= '0;
      valid_q     <= '0;
      s1_q        <= 1'b0;
    end else begin
      blink_cnt_q <= blink_cnt_d;
      blink_on_q  <= blink_on_d;
      scan_q      <= scan_d;
      s1_q        <= tick_fire;
      if (mem_wr.en) begin
        valid_q[mem_wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      s1_digit_q <= scan_d;
      s1_vbit_q  <= valid_q[scan_d];
      s1_blank_q <= ~blink_on_d & flash_q[scan_d];
      s1_point_q <= point_q[scan_d];
    end
  end

  ssd_ram #(
    .WIDTH(ssd_pkg::CODE_W),
    .DEPTH(ssd_pkg::MEM_DEPTH)
  ) u_codes (
    .clk_i  (clk_i),
    .we_i   (mem_wr.en),
    .waddr_i(mem_wr.addr),
    .wdata_i(mem_wr.data),
    .re_i   (tick_fire),
    .raddr_i(scan_d),
    .rdata_o(rdata)
  );

  ssd_show u_show (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(show_fire),
    .value_i(s_axis_tdata_i[15:0]),
    .busy_o (show_busy),
    .wr_o   (show_wr)
  );

  always_comb begin
    code = s1_vbit_q ? rdata : {2'b00, s1_digit_q};
    sel  = ~(8'd1 << s1_digit_q);
    if (s1_blank_q) begin
      seg = 8'h00;
    end else begin
      seg = ssd_pkg::glyph_seg(code) | (s1_point_q ? ssd_pkg::POINT_SEG : 8'h00);
    end
    word_req.load = s1_q;
    word_req.word = {sel, seg};
  end

  ssd_shift u_shift (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (word_req),
    .full_o     (pw_full),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_bit_o  (m_axis_tdata_o[0]),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o[7:1] = '0;

  `ASSERT_NEVER(a_s1_into_full, s1_q && pw_full, "composed word found the buffer full")
  `ASSERT_CLK(a_s1_lands, s1_q |=> pw_full, "composed word did not reach the buffer")
  `ASSERT_NEVER(a_wr_on_read, mem_wr.en && tick_fire, "digit RAM write collides with a tick")
  `ASSERT_CLK(a_show_len, show_fire |=> show_busy, "show did not start its sequence")

endmodule
